FILE: hdl/ers_pkg.sv
// ers_pkg: shared constants, types and helper functions of the Euclidean rhythm sequencer.
// No dependencies; imported by ers_div and euclidean_rhythm_sequencer.
`default_nettype none

package ers_pkg;

    // Longest pattern the sequencer stores; the effective length saturates here.
    localparam int MAX_STEPS = 64;
    localparam int LEN_CAP   = (MAX_STEPS < 64) ? MAX_STEPS : 64;

    localparam int LEN_W     = 7;    // length, beats and divisor width
    localparam int POS_W     = 6;    // step index width
    localparam int OFS_W     = 6;    // rotation and xor offset width
    localparam int DVD_W     = POS_W + LEN_W;   // dividend: step times beats
    localparam int DCNT_W    = $clog2(DVD_W + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEPS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEATS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_OFFSET = 3'd4;

    // Status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Effective pattern length: zero acts as one, large values saturate.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] steps);
        logic [LEN_W-1:0] n;
        n = steps;
        if (n == '0)
            n = LEN_W'(1);
        else if (n > LEN_W'(LEN_CAP))
            n = LEN_W'(LEN_CAP);
        return n;
    endfunction

    // Base gate from (p*beats) mod n: a beat lands on p exactly when the
    // remainder falls below beats. Covers p of zero as well.
    function automatic logic base_gate(input logic [LEN_W-1:0] rem,
                                       input logic [LEN_W-1:0] beats,
                                       input logic [LEN_W-1:0] n);
        logic g;
        if (beats == '0)
            g = 1'b0;
        else if (beats >= n)
            g = 1'b1;
        else
            g = (rem < beats);
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ers_div.sv
// ers_div: shared restoring remainder unit, one dividend bit per cycle.
// Depends on ers_pkg for widths and the status struct.
`default_nettype none

module ers_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ers_pkg::DVD_W-1:0] dividend,
    input  wire logic [ers_pkg::LEN_W-1:0] divisor,
    output ers_pkg::div_status_t           status,
    output logic      [ers_pkg::LEN_W-1:0] rem
);
    import ers_pkg::*;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = DCNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next bit, subtract when it fits
            if (trial >= {1'b0, dsr_reg})
                rem_next = LEN_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[LEN_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign rem         = rem_reg;

endmodule

`default_nettype wire

FILE: hdl/euclidean_rhythm_sequencer.sv
// euclidean_rhythm_sequencer: top level, request handshakes, configuration and sequencer.
// Depends on ers_pkg and instantiates ers_div.
`default_nettype none

// Each accepted request is one clock tick of the rhythm: the block emits the
// gate of the current step with its index and an end-of-pattern flag; the
// step counter advances on accept and wraps at the configured length (restart
// forces step 0 for this tick). The pattern spreads the configured number of
// beats evenly over the length, is rotated left by the rotation register and,
// with xor_enable set, is XORed with a copy shifted by xor_offset. The
// remainders run through one shared remainder unit: rotation mod length,
// offset mod length and one remainder per gate lookup. in_ready is high
// only while the sequencer is idle. The result sits in an output register
// until taken, and the next request may be accepted while it waits.
// Configuration writes are always accepted and must only be issued while
// no tick is in flight.

module euclidean_rhythm_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ers_pkg::CFG_DAT_W-1:0] cfg_data,
    // tick requests
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          restart,
    // results
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [ers_pkg::POS_W-1:0]     step_index,
    output logic                               gate,
    output logic                               cycle_end
);
    import ers_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;   // rotation mod length
    localparam logic [2:0] S_OFF  = 3'd2;   // xor offset mod length
    localparam logic [2:0] S_G1   = 3'd3;   // gate of the rotated pattern
    localparam logic [2:0] S_G2   = 3'd4;   // gate of the shifted copy
    localparam logic [2:0] S_DONE = 3'd5;   // hand result to output register

    // Add two values below n and wrap once.
    function automatic logic [POS_W-1:0] mod_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b,
                                                 input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] s;
        s = LEN_W'(a) + LEN_W'(b);
        if (s >= n)
            s = s - n;
        return s[POS_W-1:0];
    endfunction

    // configuration registers
    logic [LEN_W-1:0] steps_reg, beats_reg;
    logic [OFS_W-1:0] rotation_reg, xor_offset_reg;
    logic             xor_enable_reg;

    // sequencer state
    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] rr_reg, rr_next;
    logic [POS_W-1:0] oo_reg, oo_next;
    logic             gacc_reg, gacc_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] step_index_reg, step_index_next;
    logic             gate_reg, gate_next;
    logic             cycle_end_reg, cycle_end_next;

    // shared remainder unit
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [LEN_W-1:0] div_divisor;
    div_status_t      div_status;
    logic [LEN_W-1:0] div_rem;

    logic [LEN_W-1:0] len_now;
    logic [POS_W-1:0] k_now;
    logic [LEN_W-1:0] k_inc;
    logic [POS_W-1:0] p1, p2;
    logic             g_now;

    ers_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .rem      (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // Configuration writes; unknown indexes drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg      <= LEN_W'(16);
            beats_reg      <= LEN_W'(4);
            rotation_reg   <= '0;
            xor_enable_reg <= 1'b0;
            xor_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEPS:      steps_reg      <= cfg_data[LEN_W-1:0];
                REG_BEATS:      beats_reg      <= cfg_data[LEN_W-1:0];
                REG_ROTATION:   rotation_reg   <= cfg_data[OFS_W-1:0];
                REG_XOR_ENABLE: xor_enable_reg <= cfg_data[0];
                REG_XOR_OFFSET: xor_offset_reg <= cfg_data[OFS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        len_now = eff_len(steps_reg);
        // restart, or a counter left beyond a shortened length, starts at step 0
        if (restart || (LEN_W'(pos_reg) >= len_now))
            k_now = '0;
        else
            k_now = pos_reg;
        k_inc = LEN_W'(k_now) + LEN_W'(1);
        p1    = mod_add(k_reg, rr_reg, n_reg);
        p2    = mod_add(mod_add(k_reg, oo_reg, n_reg), rr_reg, n_reg);
        g_now = base_gate(div_rem, beats_reg, n_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        rr_next         = rr_reg;
        oo_next         = oo_reg;
        gacc_next       = gacc_reg;
        out_valid_next  = out_valid_reg;
        step_index_next = step_index_reg;
        gate_next       = gate_reg;
        cycle_end_next  = cycle_end_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = n_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // latch length and step, advance the counter at once
                    n_next       = len_now;
                    k_next       = k_now;
                    pos_next     = (k_inc >= len_now) ? '0 : k_inc[POS_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(rotation_reg);
                    div_divisor  = len_now;
                    state_next   = S_ROT;
                end
            end
            S_ROT:
            begin
                if (div_status.done)
                begin
                    rr_next      = div_rem[POS_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(xor_offset_reg);
                    state_next   = S_OFF;
                end
            end
            S_OFF:
            begin
                if (div_status.done)
                begin
                    oo_next      = div_rem[POS_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(p1) * DVD_W'(beats_reg);
                    state_next   = S_G1;
                end
            end
            S_G1:
            begin
                if (div_status.done)
                begin
                    gacc_next = g_now;
                    if (xor_enable_reg)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DVD_W'(p2) * DVD_W'(beats_reg);
                        state_next   = S_G2;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_G2:
            begin
                if (div_status.done)
                begin
                    gacc_next  = gacc_reg ^ g_now;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    step_index_next = k_reg;
                    gate_next       = gacc_reg;
                    cycle_end_next  = (LEN_W'(k_reg) == (n_reg - LEN_W'(1)));
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        rr_reg         <= rr_next;
        oo_reg         <= oo_next;
        gacc_reg       <= gacc_next;
        step_index_reg <= step_index_next;
        gate_reg       <= gate_next;
        cycle_end_reg  <= cycle_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign step_index = step_index_reg;
    assign gate       = gate_reg;
    assign cycle_end  = cycle_end_reg;

    // An accepted request always sets the remainder unit going.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ROT) && div_status.busy)
        else $error("accepted request did not start the remainder unit");

    // The latched step always lies inside the latched length.
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (LEN_W'(k_reg) < n_reg))
        else $error("step index outside pattern length");

    // A remainder only completes while the sequencer waits for one.
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_ROT || state_reg == S_OFF
                             || state_reg == S_G1 || state_reg == S_G2))
        else $error("remainder completed outside a waiting state");

    // The remainder unit is never restarted mid-division.
    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire
